@@ hdl/bba_pkg.sv @@
// Package for the bitmap block allocator: constants, codes and shared types.
package bba_pkg;

    localparam int DEFAULT_CAPACITY = 4096;
    localparam int WORD_BITS        = 64;
    localparam int POS_W            = 6;
    localparam int INDEX_W          = 12;
    localparam int COUNT_W          = 13;
    localparam int INDEX_SPAN       = 4096;
    localparam int COUNT_MAX        = 8191;
    localparam int RESET_TOTAL      = 4096;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_TEST    = 2'd2,
        REQ_CLAIM   = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_OOB      = 3'd1,
        STS_NOT_SET  = 3'd2,
        STS_DUP      = 3'd3,
        STS_NO_SPACE = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOOKUP,
        ST_DONE
    } state_t;

endpackage

@@ hdl/bba_req_if.sv @@
// Request channel: valid/ready handshake carrying one allocator request item.
interface bba_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           req_type;
    logic [bba_pkg::INDEX_W-1:0]          unit_index;

    modport source (output valid, output req_type, output unit_index, input ready);
    modport sink   (input valid, input req_type, input unit_index, output ready);
endinterface

@@ hdl/bba_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one allocator result item.
interface bba_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [2:0]                           status;
    logic [bba_pkg::INDEX_W-1:0]          granted_index;
    logic                                 bit_is_set;
    logic [bba_pkg::COUNT_W-1:0]          free_units;

    modport source (output valid, output status, output granted_index,
                    output bit_is_set, output free_units, input ready);
    modport sink   (input valid, input status, input granted_index,
                    input bit_is_set, input free_units, output ready);
endinterface

@@ hdl/bba_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/bitmap_block_allocator_top.sv @@
// Top level of the bitmap block allocator: sequencer, bitmap RAM and free count.
// The allocation bitmap is kept in a RAM of 64-bit words, one word per 64 units,
// covering min(CAPACITY, 4096) units; a valid flop per word stands in for the reset
// clear, so the block takes requests right after reset with no clearing pass. One
// request is worked at a time. Release, test and claim read the word from the RAM (none
// when the index is out of range); release and claim then modify and write it back.
// Allocate scans the bitmap one word per cycle through the RAM read port, reading words
// up to the first free unit, at most ceil(limit / 64) words, 64 for the full 4096 units.
// The usable limit is the smaller of total_units, CAPACITY and 4096. A finished result
// sits in an output register, and the next request is accepted while it waits. Writing
// total_units changes only the bound; the bitmap and the free count keep their values
// until reset.
module bitmap_block_allocator_top #(
    parameter int CAPACITY = bba_pkg::DEFAULT_CAPACITY
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bba_pkg::COUNT_W-1:0] cfg_data,
    bba_req_if.sink                     req,
    bba_rsp_if.source                   rsp
);

    localparam int UNIT_SPAN = (CAPACITY < bba_pkg::INDEX_SPAN) ? CAPACITY
                                                                : bba_pkg::INDEX_SPAN;
    localparam int WORDS     = (UNIT_SPAN + bba_pkg::WORD_BITS - 1) / bba_pkg::WORD_BITS;
    localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW        = bba_pkg::COUNT_W;
    localparam int XW        = CW + 1;
    localparam int IW        = bba_pkg::INDEX_W;
    localparam int WB        = bba_pkg::WORD_BITS;
    localparam int PW        = bba_pkg::POS_W;

    bba_pkg::state_t    state_reg, state_next;
    bba_pkg::req_type_t kind_reg, kind_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      rd_addr_reg, rd_addr_next;
    logic [WORDS-1:0]   row_valid_reg, row_valid_next;
    logic [CW-1:0]      total_units_reg;
    logic [CW-1:0]      free_count_reg, free_count_next;
    bba_pkg::status_t   res_status_reg, res_status_next;
    logic [IW-1:0]      res_granted_reg, res_granted_next;
    logic               res_isset_reg, res_isset_next;

    logic               out_valid_reg, out_valid_next;
    bba_pkg::status_t   out_status_reg;
    logic [IW-1:0]      out_granted_reg;
    logic               out_isset_reg;
    logic [CW-1:0]      out_free_reg;

    logic               ram_we, ram_re;
    logic [WB-1:0]      ram_wdata, ram_rdata;

    logic [CW-1:0]      lim;
    logic               accept, lim_zero, idx_oob, load_out;
    logic [WB-1:0]      rd_word, idx_mask;
    logic               idx_bit, found;
    logic [PW-1:0]      pos;
    logic [XW-1:0]      cand, next_base;
    logic               scan_hit, scan_miss;
    logic [CW-1:0]      count_dec, count_inc;

    bba_ram #(
        .WIDTH (WB),
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (rd_addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr_next),
        .rdata (ram_rdata)
    );

    // shared decode
    always_comb
    begin
        lim       = (total_units_reg > CW'(UNIT_SPAN)) ? CW'(UNIT_SPAN) : total_units_reg;
        accept    = req.valid && (state_reg == bba_pkg::ST_IDLE);
        lim_zero  = (lim == '0);
        idx_oob   = ({1'b0, req.unit_index} >= lim);
        load_out  = (state_reg == bba_pkg::ST_DONE) && (!out_valid_reg || rsp.ready);
        // a word never written reads as all clear
        rd_word   = row_valid_reg[rd_addr_reg] ? ram_rdata : '0;
        idx_mask  = WB'(1) << idx_reg[PW-1:0];
        idx_bit   = rd_word[idx_reg[PW-1:0]];
        found     = ~&rd_word;
        pos       = '0;
        for (int b = WB - 1; b >= 0; b--)
        begin
            if (!rd_word[b])
            begin
                pos = PW'(b);
            end
        end
        cand      = (XW'(rd_addr_reg) << PW) | XW'(pos);
        next_base = (XW'(rd_addr_reg) + XW'(1)) << PW;
        scan_hit  = found && (cand < {1'b0, lim});
        scan_miss = found ? !scan_hit : (next_base >= {1'b0, lim});
        count_dec = (free_count_reg == '0) ? free_count_reg : free_count_reg - CW'(1);
        count_inc = (free_count_reg == CW'(bba_pkg::COUNT_MAX)) ? free_count_reg
                                                                : free_count_reg + CW'(1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (bba_pkg::req_type_t'(req.req_type) == bba_pkg::REQ_ALLOC)
                    begin
                        state_next = lim_zero ? bba_pkg::ST_DONE : bba_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = idx_oob ? bba_pkg::ST_DONE : bba_pkg::ST_LOOKUP;
                    end
                end
            end
            bba_pkg::ST_SCAN:
            begin
                if (scan_hit || scan_miss)
                begin
                    state_next = bba_pkg::ST_DONE;
                end
            end
            bba_pkg::ST_LOOKUP:
            begin
                state_next = bba_pkg::ST_DONE;
            end
            bba_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        req.ready        = (state_reg == bba_pkg::ST_IDLE);
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        rd_addr_next     = rd_addr_reg;
        row_valid_next   = row_valid_reg;
        free_count_next  = free_count_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        res_isset_next   = res_isset_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_wdata        = rd_word;
        out_valid_next   = load_out ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

        unique case (state_reg)
            bba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next        = bba_pkg::req_type_t'(req.req_type);
                    idx_next         = req.unit_index;
                    res_status_next  = bba_pkg::STS_OK;
                    res_granted_next = '0;
                    res_isset_next   = 1'b0;
                    if (bba_pkg::req_type_t'(req.req_type) == bba_pkg::REQ_ALLOC)
                    begin
                        if (lim_zero)
                        begin
                            res_status_next = bba_pkg::STS_NO_SPACE;
                        end
                        else
                        begin
                            ram_re       = 1'b1;
                            rd_addr_next = '0;
                        end
                    end
                    else if (idx_oob)
                    begin
                        // out-of-range test just reports clear
                        if (bba_pkg::req_type_t'(req.req_type) != bba_pkg::REQ_TEST)
                        begin
                            res_status_next = bba_pkg::STS_OOB;
                        end
                    end
                    else
                    begin
                        ram_re       = 1'b1;
                        rd_addr_next = AW'(req.unit_index >> PW);
                    end
                end
            end
            bba_pkg::ST_SCAN:
            begin
                if (scan_hit)
                begin
                    ram_we                      = 1'b1;
                    ram_wdata                   = rd_word | (WB'(1) << pos);
                    row_valid_next[rd_addr_reg] = 1'b1;
                    res_granted_next            = IW'(cand);
                    free_count_next             = count_dec;
                end
                else if (scan_miss)
                begin
                    res_status_next = bba_pkg::STS_NO_SPACE;
                end
                else
                begin
                    ram_re       = 1'b1;
                    rd_addr_next = rd_addr_reg + AW'(1);
                end
            end
            bba_pkg::ST_LOOKUP:
            begin
                unique case (kind_reg)
                    bba_pkg::REQ_RELEASE:
                    begin
                        if (!idx_bit)
                        begin
                            res_status_next = bba_pkg::STS_NOT_SET;
                        end
                        else
                        begin
                            ram_we                      = 1'b1;
                            ram_wdata                   = rd_word & ~idx_mask;
                            row_valid_next[rd_addr_reg] = 1'b1;
                            free_count_next             = count_inc;
                        end
                    end
                    bba_pkg::REQ_CLAIM:
                    begin
                        if (idx_bit)
                        begin
                            res_status_next = bba_pkg::STS_DUP;
                        end
                        else
                        begin
                            ram_we                      = 1'b1;
                            ram_wdata                   = rd_word | idx_mask;
                            row_valid_next[rd_addr_reg] = 1'b1;
                        end
                    end
                    bba_pkg::REQ_TEST:
                    begin
                        res_isset_next = idx_bit;
                    end
                    default:
                    begin
                        res_status_next = bba_pkg::STS_OK;
                    end
                endcase
            end
            bba_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bba_pkg::ST_IDLE;
            row_valid_reg   <= '0;
            total_units_reg <= CW'(bba_pkg::RESET_TOTAL);
            free_count_reg  <= CW'(bba_pkg::RESET_TOTAL);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_valid_reg  <= row_valid_next;
            free_count_reg <= free_count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                total_units_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        idx_reg         <= idx_next;
        rd_addr_reg     <= rd_addr_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        res_isset_reg   <= res_isset_next;
        if (load_out)
        begin
            out_status_reg  <= res_status_reg;
            out_granted_reg <= res_granted_reg;
            out_isset_reg   <= res_isset_reg;
            out_free_reg    <= free_count_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.granted_index = out_granted_reg;
    assign rsp.bit_is_set    = out_isset_reg;
    assign rsp.free_units    = out_free_reg;

    a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bba_pkg::ST_SCAN && scan_hit) |-> (cand < {1'b0, lim}))
        else $error("allocate granted a unit beyond the limit");

    a_isset_only_test: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && res_isset_reg) |->
        (kind_reg == bba_pkg::REQ_TEST && res_status_reg == bba_pkg::STS_OK))
        else $error("bit_is_set raised for a request other than test");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bba_pkg::ST_DONE))
        else $error("result presented without a finished request");

    a_no_rw_same_word: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (rd_addr_next != rd_addr_reg))
        else $error("RAM read and write hit the same word");

    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> row_valid_reg[$past(rd_addr_reg)])
        else $error("written word not marked valid");

endmodule
